[sv/msf_pkg.sv]
// ----------------------------------------------------------------------------
// msf_pkg: shared definitions for the Moliere screening function unit
// Fixed-point widths, rate and coefficient constants, and the 2^-f table.
// ----------------------------------------------------------------------------
package msf_pkg;

   // fixed-point precision of the internal datapath
   localparam int FRAC_BITS           = 16;
   localparam int EXP_TABLE_ADDR_BITS = 6;

   localparam int ROOT_COUNT     = 10;
   localparam int TERM_COUNT     = 3;
   localparam int EXP_TABLE_SIZE = 1 << EXP_TABLE_ADDR_BITS;
   localparam int TABLE_IDX_W    = EXP_TABLE_ADDR_BITS + 1;

   // datapath widths
   localparam int DIST_W    = 32;
   localparam int UF_W      = FRAC_BITS + 6;
   localparam int RATE_W    = FRAC_BITS + 4;
   localparam int COEF_W    = FRAC_BITS + 1;
   localparam int ZPROD_W   = UF_W + RATE_W + 1;
   localparam int NUM_W     = $clog2(FRAC_BITS + 2);
   localparam int ENTRY_W   = 33;
   localparam int DIFF_W    = 32;
   localparam int REM_W     = 32 - EXP_TABLE_ADDR_BITS;
   localparam int IPROD_W   = DIFF_W + REM_W;
   localparam int MANT_W    = FRAC_BITS + 1;
   localparam int PROD_W    = COEF_W + MANT_W;
   localparam int SHIFT_W   = $clog2(2 * FRAC_BITS + 2);
   localparam int TERM_W    = FRAC_BITS + 2;
   localparam int SUM_W     = TERM_W + 2;
   localparam int OUT_W     = 17;
   localparam int OUT_MAX   = 131071;

   // register map (word index on the configuration port)
   localparam logic REG_INV_RADIUS = 1'b0;
   localparam logic [31:0] INV_RADIUS_RESET = 32'd65536;

   typedef logic [63:0] q32_type;
   typedef logic [ENTRY_W-1:0] exp_table_type [0:EXP_TABLE_SIZE];

   // stage enables handed to each term lane
   typedef struct packed {
      logic s2;
      logic s3;
      logic s4;
      logic s5;
      logic s6;
      logic s7;
   } stage_en_type;

   // alpha_i / beta_i in Q32.32
   localparam q32_type COEF_Q32 [0:2] = '{64'd71582788, 64'd1968526677, 64'd5010795179};
   // beta_i * log2(e) in Q32.32
   localparam q32_type RATE_Q32 [0:2] = '{64'd37177968112, 64'd7435593622, 64'd1858898406};
   // 2^-(2^-k) for k = 1..10 in Q0.32
   localparam q32_type ROOT_Q32 [0:ROOT_COUNT-1] = '{
      64'd3037000500, 64'd3611622603, 64'd3938502376, 64'd4112874773, 64'd4202935004,
      64'd4248701965, 64'd4271771997, 64'd4283353945, 64'd4289156690, 64'd4292061010
   };

   // round a Q0.32 constant to nearest in Q.FRAC_BITS
   function automatic q32_type to_frac(q32_type q);
      to_frac = (q + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
   endfunction

   // Q0.32 product rounded to nearest
   function automatic q32_type mul_q32(q32_type a, q32_type b);
      mul_q32 = (a * b + (64'd1 << 31)) >> 32;
   endfunction

   // 2^-(j / 2^EXP_TABLE_ADDR_BITS) in Q0.32, last entry 0.5
   function automatic exp_table_type build_exp_table();
      exp_table_type t;
      q32_type v;
      for (int j = 0; j <= EXP_TABLE_SIZE; j++) begin
         if (j >= EXP_TABLE_SIZE) begin
            v = 64'd1 << 31;
         end else begin
            v = 64'd1 << 32;
            for (int k = 0; k < EXP_TABLE_ADDR_BITS && k < ROOT_COUNT; k++) begin
               if (((j >> (EXP_TABLE_ADDR_BITS - 1 - k)) & 1) != 0) begin
                  v = mul_q32(v, ROOT_Q32[k]);
               end
            end
         end
         t[j] = v[ENTRY_W-1:0];
      end
      build_exp_table = t;
   endfunction

   localparam exp_table_type EXP_TABLE = build_exp_table();

   // per-term constants at internal precision
   localparam logic [RATE_W-1:0] RATE_FRAC [0:2] = '{
      RATE_W'(to_frac(RATE_Q32[0])), RATE_W'(to_frac(RATE_Q32[1])),
      RATE_W'(to_frac(RATE_Q32[2]))
   };
   localparam logic [COEF_W-1:0] COEF_FRAC [0:2] = '{
      COEF_W'(to_frac(COEF_Q32[0])), COEF_W'(to_frac(COEF_Q32[1])),
      COEF_W'(to_frac(COEF_Q32[2]))
   };

endpackage

[sv/moliere_screening_function_unit.sv]
// ----------------------------------------------------------------------------
// moliere_screening_function_unit: Moliere screening value of a distance
// Sum of three scaled exponentials of |distance| * inv_screening_radius,
// fully pipelined, saturating Q1.16 result.
// ----------------------------------------------------------------------------
//
//  channel  | handshake             | payload
//  ---------+-----------------------+----------------------------------------
//  request  | req_valid / req_ready | req_distance, signed Q16.16
//  response | rsp_valid / rsp_ready | rsp_screening_value, unsigned Q1.16
//  config   | psel/penable/pwrite   | paddr, pwdata, prdata (inv radius Q16.16)
//
//  one word per cycle sustained while rsp_ready is high; rsp_valid rises once
//  the word has passed the eight register stages (radius product, exponent,
//  table lookup, interpolation product, mantissa, coefficient product, shift,
//  sum)
//  each stage advances when it is empty or the stage after it advances, so a
//  stalled response holds its word while bubbles ahead of it are filled
//  synchronous reset clears the stage valid bits and sets the radius register to 65536
//
module moliere_screening_function_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic signed [31:0]          req_distance,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [16:0]                 rsp_screening_value,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [2:0]                  paddr,
   input  logic [31:0]                 pwdata,
   output logic [31:0]                 prdata,
   output logic                        pready
);

   localparam int F      = msf_pkg::FRAC_BITS;
   localparam int STAGES = 8;

   // configuration register
   logic [31:0] inv_radius_ff;
   logic        csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && (paddr[2] == msf_pkg::REG_INV_RADIUS);
   assign prdata    = (paddr[2] == msf_pkg::REG_INV_RADIUS) ? inv_radius_ff : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         inv_radius_ff <= msf_pkg::INV_RADIUS_RESET;
      end else if (csr_write) begin
         inv_radius_ff <= pwdata;
      end
   end

   // stage valid bits and enables
   logic [STAGES:1] valid_ff;
   logic [STAGES+1:1] advance;
   msf_pkg::stage_en_type en;

   always_comb begin
      advance[STAGES+1] = rsp_ready;
      for (int k = STAGES; k >= 1; k--) begin
         advance[k] = !valid_ff[k] || advance[k+1];
      end
   end

   assign req_ready = advance[1];
   assign en = '{s2: advance[2], s3: advance[3], s4: advance[4],
                 s5: advance[5], s6: advance[6], s7: advance[7]};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (advance[1]) begin
            valid_ff[1] <= req_valid;
         end
         for (int k = 2; k <= STAGES; k++) begin
            if (advance[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   // stage 1: magnitude times reciprocal radius, range check
   logic [31:0]               dist_mag;
   logic [63:0]               uprod;
   logic [msf_pkg::UF_W-1:0]  uf_in, uf_ff;
   logic                      in_range_in, in_range_ff;

   always_comb begin
      dist_mag    = req_distance[31] ? (~req_distance + 32'd1) : req_distance;
      uprod       = 64'(dist_mag) * 64'(inv_radius_ff);
      in_range_in = (uprod[63:38] == '0);
      uf_in       = uprod[37:32-F];
   end

   always_ff @(posedge clock) begin
      if (advance[1]) begin
         uf_ff       <= uf_in;
         in_range_ff <= in_range_in;
      end
   end

   // stages 2 to 7: one lane per term
   logic [msf_pkg::TERM_W-1:0] term [0:msf_pkg::TERM_COUNT-1];

   for (genvar i = 0; i < msf_pkg::TERM_COUNT; i++) begin : g_term
      msf_term u_term (
         .clock    (clock),
         .en       (en),
         .uf       (uf_ff),
         .in_range (in_range_ff),
         .rate     (msf_pkg::RATE_FRAC[i]),
         .coef     (msf_pkg::COEF_FRAC[i]),
         .term     (term[i])
      );
   end

   // stage 8: sum, scale to Q1.16 and saturate
   localparam int DOWN     = (F > 16) ? F - 16 : 0;
   localparam int UP       = (F < 16) ? 16 - F : 0;
   localparam int WIDE_W   = msf_pkg::SUM_W + UP + 1;
   localparam int DOWN_RND = (1 << DOWN) >> 1;

   logic [msf_pkg::SUM_W-1:0] sum;
   logic [WIDE_W-1:0]         scaled;
   logic [16:0]               result_in, result_ff;

   always_comb begin
      sum = msf_pkg::SUM_W'(term[0]) + msf_pkg::SUM_W'(term[1]) + msf_pkg::SUM_W'(term[2]);
      scaled = ((WIDE_W'(sum) + WIDE_W'(DOWN_RND)) >> DOWN) << UP;
      if (scaled > WIDE_W'(msf_pkg::OUT_MAX)) begin
         result_in = msf_pkg::OUT_W'(msf_pkg::OUT_MAX);
      end else begin
         result_in = scaled[16:0];
      end
   end

   always_ff @(posedge clock) begin
      if (advance[8]) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid           = valid_ff[STAGES];
   assign rsp_screening_value = result_ff;

endmodule

[sv/msf_term.sv]
// ----------------------------------------------------------------------------
// msf_term: one exponential term lane
// Computes round((coef * 2^-frac(z)) >> (FRAC_BITS + int(z))) with z = uf * rate,
// over six register stages driven by the shared stage enables.
// ----------------------------------------------------------------------------
module msf_term (
   input  logic                              clock,
   input  msf_pkg::stage_en_type             en,
   input  logic [msf_pkg::UF_W-1:0]          uf,
   input  logic                              in_range,
   input  logic [msf_pkg::RATE_W-1:0]        rate,
   input  logic [msf_pkg::COEF_W-1:0]        coef,
   output logic [msf_pkg::TERM_W-1:0]        term
);

   localparam int F = msf_pkg::FRAC_BITS;
   localparam int A = msf_pkg::EXP_TABLE_ADDR_BITS;

   // stage 2: exponent z, split into integer and fraction
   logic [msf_pkg::ZPROD_W-1:0]  zprod;
   logic [msf_pkg::ZPROD_W-F-1:0] znum;
   logic [F-1:0]                 frac_s2_in, frac_s2_ff;
   logic [msf_pkg::NUM_W-1:0]    num_s2_in, num_s2_ff;
   logic                         zero_s2_in, zero_s2_ff;

   always_comb begin
      zprod      = msf_pkg::ZPROD_W'(uf) * msf_pkg::ZPROD_W'(rate)
                   + (msf_pkg::ZPROD_W'(1) << (F - 1));
      znum       = zprod[msf_pkg::ZPROD_W-1:2*F];
      frac_s2_in = zprod[2*F-1:F];
      num_s2_in  = znum[msf_pkg::NUM_W-1:0];
      zero_s2_in = !in_range || (znum >= (msf_pkg::ZPROD_W-F)'(F + 2));
   end

   always_ff @(posedge clock) begin
      if (en.s2) begin
         frac_s2_ff <= frac_s2_in;
         num_s2_ff  <= num_s2_in;
         zero_s2_ff <= zero_s2_in;
      end
   end

   // stage 3: table lookup of the two neighbouring entries
   logic [31:0]                    f32;
   logic [msf_pkg::TABLE_IDX_W-1:0] idx0, idx1;
   logic [msf_pkg::ENTRY_W-1:0]    t0, t1;
   logic [msf_pkg::ENTRY_W-1:0]    t0_s3_ff;
   logic [msf_pkg::DIFF_W-1:0]     diff_s3_in, diff_s3_ff;
   logic [msf_pkg::REM_W-1:0]      rem_s3_ff;
   logic [msf_pkg::NUM_W-1:0]      num_s3_ff;
   logic                           zero_s3_ff;

   always_comb begin
      f32        = {frac_s2_ff, (32 - F)'(0)};
      idx0       = {1'b0, f32[31 -: A]};
      idx1       = idx0 + msf_pkg::TABLE_IDX_W'(1);
      t0         = msf_pkg::EXP_TABLE[idx0];
      t1         = msf_pkg::EXP_TABLE[idx1];
      diff_s3_in = msf_pkg::DIFF_W'(t0 - t1);
   end

   always_ff @(posedge clock) begin
      if (en.s3) begin
         t0_s3_ff   <= t0;
         diff_s3_ff <= diff_s3_in;
         rem_s3_ff  <= f32[msf_pkg::REM_W-1:0];
         num_s3_ff  <= num_s2_ff;
         zero_s3_ff <= zero_s2_ff;
      end
   end

   // stage 4: interpolation product
   logic [msf_pkg::IPROD_W-1:0] iprod_s4_in, iprod_s4_ff;
   logic [msf_pkg::ENTRY_W-1:0] t0_s4_ff;
   logic [msf_pkg::NUM_W-1:0]   num_s4_ff;
   logic                        zero_s4_ff;

   assign iprod_s4_in = msf_pkg::IPROD_W'(diff_s3_ff) * msf_pkg::IPROD_W'(rem_s3_ff);

   always_ff @(posedge clock) begin
      if (en.s4) begin
         iprod_s4_ff <= iprod_s4_in;
         t0_s4_ff    <= t0_s3_ff;
         num_s4_ff   <= num_s3_ff;
         zero_s4_ff  <= zero_s3_ff;
      end
   end

   // stage 5: mantissa 2^-frac in Q0.32, rounded to internal precision
   logic [msf_pkg::ENTRY_W:0]  mant32;
   logic [msf_pkg::ENTRY_W:0]  mant_rnd;
   logic [msf_pkg::MANT_W-1:0] mant_s5_in, mant_s5_ff;
   logic [msf_pkg::NUM_W-1:0]  num_s5_ff;
   logic                       zero_s5_ff;

   always_comb begin
      mant32     = (msf_pkg::ENTRY_W + 1)'(t0_s4_ff)
                   - (msf_pkg::ENTRY_W + 1)'(iprod_s4_ff[msf_pkg::IPROD_W-1:msf_pkg::REM_W]);
      mant_rnd   = (mant32 + ((msf_pkg::ENTRY_W + 1)'(1) << (31 - F))) >> (32 - F);
      mant_s5_in = mant_rnd[msf_pkg::MANT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (en.s5) begin
         mant_s5_ff <= mant_s5_in;
         num_s5_ff  <= num_s4_ff;
         zero_s5_ff <= zero_s4_ff;
      end
   end

   // stage 6: coefficient times mantissa
   logic [msf_pkg::PROD_W-1:0] prod_s6_in, prod_s6_ff;
   logic [msf_pkg::NUM_W-1:0]  num_s6_ff;
   logic                       zero_s6_ff;

   assign prod_s6_in = msf_pkg::PROD_W'(coef) * msf_pkg::PROD_W'(mant_s5_ff);

   always_ff @(posedge clock) begin
      if (en.s6) begin
         prod_s6_ff <= prod_s6_in;
         num_s6_ff  <= num_s5_ff;
         zero_s6_ff <= zero_s5_ff;
      end
   end

   // stage 7: rounding right shift by FRAC_BITS + int(z)
   logic [msf_pkg::SHIFT_W-1:0] shamt;
   logic [msf_pkg::PROD_W:0]    shifted;
   logic [msf_pkg::TERM_W-1:0]  term_in, term_ff;

   always_comb begin
      shamt   = msf_pkg::SHIFT_W'(F) + msf_pkg::SHIFT_W'(num_s6_ff);
      shifted = ((msf_pkg::PROD_W + 1)'(prod_s6_ff)
                + ((msf_pkg::PROD_W + 1)'(1) << (shamt - msf_pkg::SHIFT_W'(1)))) >> shamt;
      term_in = zero_s6_ff ? '0 : shifted[msf_pkg::TERM_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (en.s7) begin
         term_ff <= term_in;
      end
   end

   assign term = term_ff;

endmodule

[dv/moliere_screening_value_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// moliere_screening_value_checker: watches the request, response and register
// ports, works out the screening value of every accepted distance word and
// compares it with the response words in order of arrival.
// ----------------------------------------------------------------------------
module moliere_screening_value_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [31:0] req_distance,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [16:0] rsp_screening_value,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   input  logic        pready,
   output int          error_count,
   output int          pending_words,
   output int          checked_words,
   output int          zero_words
);

   // internal precision of the datapath and size of the 2^-f table
   localparam int FRAC      = 16;
   localparam int TBL_BITS  = 6;
   localparam int TBL_SIZE  = 1 << TBL_BITS;
   localparam int ROOTS     = 10;
   localparam int REPORT_MAX = 10;

   localparam int          INV_RADIUS_INDEX    = 0;
   localparam logic [31:0] INV_RADIUS_AT_RESET = 32'd65536;
   localparam logic [63:0] SCREENING_MAX       = 64'd131071;

   // alpha / beta per term, Q32.32
   localparam logic [63:0] ALPHA_OVER_BETA_Q32 [3] =
      '{64'd71582788, 64'd1968526677, 64'd5010795179};
   // beta * log2(e) per term, Q32.32
   localparam logic [63:0] DECAY_RATE_Q32 [3] =
      '{64'd37177968112, 64'd7435593622, 64'd1858898406};
   // 2^-(2^-k), k = 1..10, Q0.32
   localparam logic [63:0] HALVING_ROOT_Q32 [ROOTS] = '{
      64'd3037000500, 64'd3611622603, 64'd3938502376, 64'd4112874773, 64'd4202935004,
      64'd4248701965, 64'd4271771997, 64'd4283353945, 64'd4289156690, 64'd4292061010
   };

   logic [63:0] pow2_table [0:TBL_SIZE];
   logic [63:0] rate_frac  [3];
   logic [63:0] coef_frac  [3];
   logic [31:0] inv_radius;
   logic [16:0] expected_values [$];

   // Q0.32 to Q.FRAC, nearest
   function automatic logic [63:0] q32_to_frac(input logic [63:0] q);
      return (q + (64'd1 << (31 - FRAC))) >> (32 - FRAC);
   endfunction

   // table of 2^-(j/64) from products of the halving roots; the extra entry is one half
   initial begin : build_constants
      logic [63:0] acc;
      for (int j = 0; j <= TBL_SIZE; j++) begin
         acc = 64'd1 << 32;
         if (j == TBL_SIZE) begin
            acc = 64'd1 << 31;
         end else begin
            for (int k = 0; k < TBL_BITS && k < ROOTS; k++) begin
               if (((j >> (TBL_BITS - 1 - k)) & 1) != 0) begin
                  acc = (acc * HALVING_ROOT_Q32[k] + (64'd1 << 31)) >> 32;
               end
            end
         end
         pow2_table[j] = acc;
      end
      for (int i = 0; i < 3; i++) begin
         rate_frac[i] = q32_to_frac(DECAY_RATE_Q32[i]);
         coef_frac[i] = q32_to_frac(ALPHA_OVER_BETA_Q32[i]);
      end
   end

   // one exponential term: integer part of the exponent is a shift, fraction is looked up
   function automatic logic [63:0] decay_term(input int i, input logic [63:0] uf);
      logic [63:0] expo, whole, frac32, rem, t0, t1, mant, prod;
      int unsigned idx, shift;
      expo  = (uf * rate_frac[i] + (64'd1 << (FRAC - 1))) >> FRAC;
      whole = expo >> FRAC;
      // too far out for the format
      if (whole >= FRAC + 2) return 64'd0;
      frac32 = (expo & ((64'd1 << FRAC) - 1)) << (32 - FRAC);
      idx    = 32'(frac32 >> (32 - TBL_BITS));
      rem    = frac32 & ((64'd1 << (32 - TBL_BITS)) - 1);
      t0     = pow2_table[idx];
      t1     = pow2_table[idx + 1];
      mant   = t0 - (((t0 - t1) * rem) >> (32 - TBL_BITS));
      prod   = coef_frac[i] * q32_to_frac(mant);
      shift  = FRAC + 32'(whole);
      return (prod + (64'd1 << (shift - 1))) >> shift;
   endfunction

   // screening value of one distance word under the current radius
   function automatic logic [16:0] screening_value_of(input logic [31:0] raw,
                                                      input logic [31:0] inv);
      logic [63:0] mag, prod_u, total;
      // only the magnitude counts; the most negative word gives 2^31
      mag    = raw[31] ? ((64'd1 << 32) - {32'd0, raw}) : {32'd0, raw};
      prod_u = mag * {32'd0, inv};
      total  = 64'd0;
      if (prod_u < (64'd64 << 32)) begin
         for (int i = 0; i < 3; i++) begin
            total += decay_term(i, prod_u >> (32 - FRAC));
         end
      end
      // FRAC equals the output fraction, so no rescale before saturation
      if (total > SCREENING_MAX) total = SCREENING_MAX;
      return total[16:0];
   endfunction

   task automatic note_mismatch(input string what, input logic [16:0] want,
                                input logic [16:0] got);
      error_count++;
      if (error_count <= REPORT_MAX) begin
         $display("[%0t] mismatch (%s): expected %0d, got %0d", $time, what, want, got);
      end
   endtask

   // register copy, prediction and comparison
   always @(posedge clock) begin : watch
      logic [16:0] oldest;
      if (reset) begin
         inv_radius = INV_RADIUS_AT_RESET;
         expected_values.delete();
         pending_words = 0;
      end else begin
         if (psel && penable && pwrite && pready && (paddr >> 2) == INV_RADIUS_INDEX) begin
            inv_radius = pwdata;
         end
         if (req_valid && req_ready) begin
            expected_values.push_back(screening_value_of(req_distance, inv_radius));
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_values.size() == 0) begin
               note_mismatch("word with nothing outstanding", 17'd0, rsp_screening_value);
            end else begin
               oldest = expected_values.pop_front();
               checked_words++;
               if (oldest == 17'd0) zero_words++;
               if (rsp_screening_value !== oldest) begin
                  note_mismatch("screening_value", oldest, rsp_screening_value);
               end
            end
         end
         pending_words = expected_values.size();
      end
   end

endmodule

[dv/moliere_screening_function_unit_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// moliere_screening_function_unit_tb: random and edge-case distance words
// Runs the unit through several reciprocal-radius settings (reset value, zero,
// all ones, one lsb, random) with random gaps and back-pressure, while the
// checker predicts and compares every response word.
// ----------------------------------------------------------------------------
module moliere_screening_function_unit_tb;

   localparam int          CYCLE_LIMIT       = 400000;
   localparam int          DRAIN_CYCLES      = 16;
   localparam int          PHASES            = 9;
   localparam logic [2:0]  CSR_INV_RADIUS    = 3'd0;
   // word address of register index one, which does not exist
   localparam logic [2:0]  CSR_UNMAPPED      = 3'd4;
   localparam int          EDGE_COUNT        = 18;

   // extremes, unit and half distances, and the points where each term drops out
   localparam logic [31:0] EDGE_DISTANCES [EDGE_COUNT] = '{
      32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
      32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000, 32'h0002_0000, 32'h0002_14A0,
      32'h000A_6666, 32'h0029_9999, 32'h000F_0000, 32'h003F_FFFF, 32'h0040_0000,
      32'hFFC0_0000, 32'hFFC0_0001, 32'h0010_0000
   };

   logic               clock = 1'b0;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic signed [31:0] req_distance;
   logic               rsp_valid;
   logic               rsp_ready;
   logic [16:0]        rsp_screening_value;
   logic               psel;
   logic               penable;
   logic               pwrite;
   logic [2:0]         paddr;
   logic [31:0]        pwdata;
   logic [31:0]        prdata;
   logic               pready;

   int          error_count;
   int          pending_words;
   int          checked_words;
   int          zero_words;
   int unsigned cycle_count = 0;
   int          gap_pct     = 0;
   int          stall_pct   = 0;
   bit          quiet       = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   moliere_screening_function_unit u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_distance        (req_distance),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_screening_value (rsp_screening_value),
      .psel                (psel),
      .penable             (penable),
      .pwrite              (pwrite),
      .paddr               (paddr),
      .pwdata              (pwdata),
      .prdata              (prdata),
      .pready              (pready)
   );

   moliere_screening_value_checker u_checker (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_distance        (req_distance),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_screening_value (rsp_screening_value),
      .psel                (psel),
      .penable             (penable),
      .pwrite              (pwrite),
      .paddr               (paddr),
      .pwdata              (pwdata),
      .pready              (pready),
      .error_count         (error_count),
      .pending_words       (pending_words),
      .checked_words       (checked_words),
      .zero_words          (zero_words)
   );

   // watchdog
   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin : watchdog
      wait (cycle_count >= CYCLE_LIMIT);
      $display("timeout after %0d cycles, %0d words outstanding", cycle_count, pending_words);
      $display("DONE: errors detected");
      $finish;
   end

   // mostly log-spread magnitudes so the product lands across the whole curve
   function automatic logic [31:0] pick_distance();
      logic [31:0] mag;
      int          kind;
      kind = $urandom_range(0, 9);
      if (kind < 2) return $urandom;
      if (kind == 2) return EDGE_DISTANCES[$urandom_range(0, EDGE_COUNT - 1)];
      mag = $urandom >> $urandom_range(0, 31);
      return $urandom_range(0, 1) ? -mag : mag;
   endfunction

   // called at a rising edge; returns at the edge that takes the word
   task automatic send_distance(input logic [31:0] distance_word);
      if (!quiet && $urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_distance <= distance_word;
      do @(negedge clock); while (!req_ready);
      @(posedge clock);
   endtask

   // setup then access cycle
   task automatic write_csr(input logic [2:0] addr, input logic [31:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(negedge clock); while (!pready);
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // response back-pressure in bursts
   initial begin : rsp_side
      rsp_ready <= 1'b0;
      wait (reset === 1'b0);
      @(posedge clock);
      forever begin
         if (!quiet && $urandom_range(0, 99) < stall_pct) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   end

   // stimulus and verdict
   initial begin : req_side
      logic [31:0] radius;
      int          words;
      int          settings;
      reset        <= 1'b1;
      req_valid    <= 1'b0;
      req_distance <= '0;
      psel         <= 1'b0;
      penable      <= 1'b0;
      pwrite       <= 1'b0;
      paddr        <= '0;
      pwdata       <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // edge cases under the reset radius
      settings  = 1;
      gap_pct   = 10;
      stall_pct = 10;
      for (int i = 0; i < EDGE_COUNT; i++) send_distance(EDGE_DISTANCES[i]);

      for (int ph = 0; ph < PHASES; ph++) begin
         // let the pipe empty before touching the register
         req_valid <= 1'b0;
         do @(negedge clock); while (pending_words != 0);
         @(posedge clock);
         case (ph)
            0: begin radius = 32'h0000_0000; words = 40;  end
            1: begin radius = 32'hFFFF_FFFF; words = 100; end
            2: begin radius = 32'h0000_0001; words = 100; end
            3: begin radius = 32'h0001_0000; words = 150; end
            4: begin radius = $urandom;      words = 150; end
            default: begin
               radius = $urandom_range(32'h0000_1000, 32'h0010_0000);
               words  = 150;
            end
         endcase
         write_csr(CSR_INV_RADIUS, radius);
         if (ph == 0 || ph == 5) write_csr(CSR_UNMAPPED, $urandom);
         settings++;
         gap_pct   = 15 * $urandom_range(0, 3);
         stall_pct = 15 * $urandom_range(0, 3);
         quiet     = (ph == PHASES - 1);
         for (int i = 0; i < words; i++) send_distance(pick_distance());
      end

      req_valid <= 1'b0;
      do @(negedge clock); while (pending_words != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("checked %0d screening words over %0d radius settings, %0d of them zero",
               checked_words, settings, zero_words);
      $display("settings took in zero, all-ones and one-lsb radius and an unmapped write");
      if (error_count == 0 && pending_words == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
